// ===== rtl/core/tvs_pkg.sv =====
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared constants and types of the trilinear volume sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

   localparam int GRID_SIZE   = 32;
   localparam int FRAC_BITS   = 8;
   localparam int AXIS_BITS   = $clog2(GRID_SIZE);
   localparam int HALF_BITS   = (AXIS_BITS > 1) ? AXIS_BITS - 1 : 1;
   localparam int NBANK       = 8;
   localparam int BANK_AW     = 3 * HALF_BITS;
   localparam int BANK_DEPTH  = 1 << BANK_AW;
   localparam int STORE_DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;

   localparam int INDEX_W   = 15;
   localparam int VOXEL_W   = 16;
   localparam int COORD_W   = 16;
   localparam int VALUE_W   = 24;
   localparam int WEIGHT_W  = FRAC_BITS + 1;
   localparam int T_W       = COORD_W + AXIS_BITS + FRAC_BITS;
   localparam int CORNER_W  = T_W - FRAC_BITS;
   localparam int W2_W      = 2 * WEIGHT_W;
   localparam int W3_W      = 3 * WEIGHT_W;
   localparam int PROD_W    = W3_W + 1 + VOXEL_W;
   localparam int SUM_W     = PROD_W + 3;

   localparam int CENTER    = (GRID_SIZE / 2) << FRAC_BITS;
   localparam int ONE_W     = 1 << FRAC_BITS;
   localparam int CORNER_MAX = GRID_SIZE - 2;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   typedef struct packed {
      logic                              valid;
      logic                              in_range;
      logic [NBANK-1:0][W2_W-1:0]        wxy;
      logic [NBANK-1:0][WEIGHT_W-1:0]    wz;
   } tvs_s1_type;

   typedef struct packed {
      logic [NBANK-1:0]                  wr_en;
      logic [BANK_AW-1:0]                wr_addr;
      logic [VOXEL_W-1:0]                wr_data;
      logic                              rd_en;
      logic [NBANK-1:0][BANK_AW-1:0]     rd_addr;
   } tvs_mem_type;

endpackage

// ===== rtl/core/tvs_ram.sv =====
// ----------------------------------------------------------------------------
// tvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tvs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/tvs_front.sv =====
// ----------------------------------------------------------------------------
// tvs_front
// Coordinate split, bank addressing, axis weights and load writes.
// ----------------------------------------------------------------------------
module tvs_front
   import tvs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      advance,
   input  logic                      req_type,
   input  logic [INDEX_W-1:0]        voxel_index,
   input  logic signed [VOXEL_W-1:0] voxel_value,
   input  logic signed [COORD_W-1:0] coord_x,
   input  logic signed [COORD_W-1:0] coord_y,
   input  logic signed [COORD_W-1:0] coord_z,
   output tvs_mem_type               mem,
   output tvs_s1_type                s1
);

   logic signed [T_W-1:0]      t_val  [3];
   logic [CORNER_W-1:0]        corner [3];
   logic [FRAC_BITS-1:0]       frac   [3];
   logic [2:0]                 ok;
   logic [INDEX_W-1:0]         lx, ly, lz;
   logic [2:0]                 wbank;
   tvs_s1_type                 s1_ff, s1_in;
   logic [CORNER_W-1:0]        ca;
   logic [HALF_BITS-1:0]       half [3];
   logic [WEIGHT_W-1:0]        w    [3];
   logic                       sel;

   assign t_val[0] = T_W'(coord_x) + T_W'(CENTER);
   assign t_val[1] = T_W'(coord_y) + T_W'(CENTER);
   assign t_val[2] = T_W'(coord_z) + T_W'(CENTER);

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         corner[a] = t_val[a][T_W-1:FRAC_BITS];
         frac[a]   = t_val[a][FRAC_BITS-1:0];
         ok[a]     = !t_val[a][T_W-1] && (corner[a] <= CORNER_W'(CORNER_MAX));
      end
   end

   assign lx    = voxel_index >> (2 * AXIS_BITS);
   assign ly    = voxel_index >> AXIS_BITS;
   assign lz    = voxel_index;
   assign wbank = {lx[0], ly[0], lz[0]};

   always_comb begin
      mem         = '0;
      s1_in       = '0;
      ca          = '0;
      sel         = 1'b0;
      half        = '{default: '0};
      w           = '{default: '0};
      mem.wr_addr = {HALF_BITS'(lx[AXIS_BITS-1:0] >> 1), HALF_BITS'(ly[AXIS_BITS-1:0] >> 1),
                     HALF_BITS'(lz[AXIS_BITS-1:0] >> 1)};
      mem.wr_data = voxel_value;
      mem.rd_en   = accept && (req_type == REQ_SAMPLE);
      for (int b = 0; b < NBANK; b++) begin
         mem.wr_en[b] = accept && (req_type == REQ_LOAD) &&
                        (32'(voxel_index) < 32'(STORE_DEPTH)) && (wbank == 3'(b));
         for (int a = 0; a < 3; a++) begin
            sel     = b[2-a] ^ corner[a][0];
            ca      = corner[a] + CORNER_W'(sel);
            half[a] = HALF_BITS'(ca >> 1);
            w[a]    = sel ? WEIGHT_W'(frac[a]) : WEIGHT_W'(ONE_W) - WEIGHT_W'(frac[a]);
         end
         mem.rd_addr[b] = {half[0], half[1], half[2]};
         s1_in.wxy[b]   = w[0] * w[1];
         s1_in.wz[b]    = w[2];
      end
      s1_in.valid    = accept && (req_type == REQ_SAMPLE);
      s1_in.in_range = &ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff <= s1_in;
      end
   end

   assign s1 = s1_ff;

endmodule

// ===== rtl/core/tvs_datapath.sv =====
// ----------------------------------------------------------------------------
// tvs_datapath
// Weight products, corner multiply, summation, rounding, saturation and result register.
// ----------------------------------------------------------------------------
module tvs_datapath
   import tvs_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  tvs_s1_type                        s1,
   input  logic [NBANK-1:0][VOXEL_W-1:0]     rd_data,
   output logic                              rsp_valid,
   output logic signed [VALUE_W-1:0]         sample_value,
   output logic                              in_range
);

   localparam logic signed [SUM_W-1:0] RND     = SUM_W'(1) << (2 * FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((1 << (VALUE_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1) << (VALUE_W - 1));

   logic                                   s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic                                   s2_rng_ff, s3_rng_ff, s4_rng_ff;
   logic [NBANK-1:0][W3_W-1:0]             w3_ff;
   logic [NBANK-1:0][VOXEL_W-1:0]          vox_ff;
   logic signed [PROD_W-1:0]               prod_ff [NBANK];
   logic signed [SUM_W-1:0]                part_ff [2];
   logic signed [SUM_W-1:0]                part_in [2];
   logic signed [SUM_W-1:0]                total, shifted, sat;
   logic                                   out_valid_ff;
   logic signed [VALUE_W-1:0]              out_value_ff;
   logic                                   out_rng_ff;

   always_comb begin
      for (int h = 0; h < 2; h++) begin
         part_in[h] = '0;
         for (int b = 0; b < 4; b++) begin
            part_in[h] = part_in[h] + SUM_W'(prod_ff[4*h+b]);
         end
      end
      total   = part_ff[0] + part_ff[1] + RND;
      shifted = total >>> (2 * FRAC_BITS);
      if (shifted > OUT_MAX) begin
         sat = OUT_MAX;
      end else if (shifted < OUT_MIN) begin
         sat = OUT_MIN;
      end else begin
         sat = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= s1.valid;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_rng_ff <= s1.in_range;
         s3_rng_ff <= s2_rng_ff;
         s4_rng_ff <= s3_rng_ff;
         out_rng_ff <= s4_rng_ff;
         vox_ff    <= rd_data;
         for (int b = 0; b < NBANK; b++) begin
            w3_ff[b]   <= s1.wxy[b] * s1.wz[b];
            prod_ff[b] <= $signed({1'b0, w3_ff[b]}) * $signed(vox_ff[b]);
         end
         part_ff      <= part_in;
         out_value_ff <= s4_rng_ff ? VALUE_W'(sat) : '0;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign sample_value = out_value_ff;
   assign in_range     = out_rng_ff;

endmodule

// ===== rtl/core/trilinear_volume_sample.sv =====
// ----------------------------------------------------------------------------
// trilinear_volume_sample
// Trilinear sampler over a banked cubic voxel volume.
// ----------------------------------------------------------------------------
// One transaction per cycle in either kind while the pipeline is not held: a
// load writes one voxel, a sample reads its eight cell corners together from
// eight parity banks (one per x, y, z parity), so every sample uses each bank's
// read port once and loads never collide with samples. A sample's result passes
// through corner read with axis weights, weight product, corner multiply, corner
// sum, then rounding into the result register. The whole pipeline holds while a
// result waits on rsp_ready.
module trilinear_volume_sample
   import tvs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [INDEX_W-1:0]        req_voxel_index,
   input  logic signed [VOXEL_W-1:0] req_voxel_value,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_sample_value,
   output logic                      rsp_in_range
);

   logic                          advance;
   logic                          accept;
   tvs_mem_type                   mem;
   tvs_s1_type                    s1;
   logic [NBANK-1:0][VOXEL_W-1:0] rd_data;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance && !reset;
   assign accept    = req_valid && req_ready;

   tvs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (advance),
      .req_type    (req_type),
      .voxel_index (req_voxel_index),
      .voxel_value (req_voxel_value),
      .coord_x     (req_coord_x),
      .coord_y     (req_coord_y),
      .coord_z     (req_coord_z),
      .mem         (mem),
      .s1          (s1)
   );

   for (genvar b = 0; b < NBANK; b++) begin : g_bank
      tvs_ram #(
         .WIDTH (VOXEL_W),
         .DEPTH (BANK_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (mem.wr_en[b]),
         .wr_addr (mem.wr_addr),
         .wr_data (mem.wr_data),
         .rd_en   (mem.rd_en),
         .rd_addr (mem.rd_addr[b]),
         .rd_data (rd_data[b])
      );
   end

   tvs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .s1           (s1),
      .rd_data      (rd_data),
      .rsp_valid    (rsp_valid),
      .sample_value (rsp_sample_value),
      .in_range     (rsp_in_range)
   );

endmodule

// ===== verif/tb_trilinear_volume_sample.sv =====
// ----------------------------------------------------------------------------
// tb_trilinear_volume_sample
// Self-checking testbench for the trilinear volume sampler.
// ----------------------------------------------------------------------------
// Loads voxel regions at both volume corners and at the centre. It then sends
// directed and random sample transactions, with loads mixed in, and checks
// every sample against an in-bench trilinear predictor. The sender idles in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_trilinear_volume_sample;
   import tvs_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 950;

   class sample_scoreboard;
      logic signed [VALUE_W-1:0] value_q[$];
      logic                      flag_q[$];
      int errors;
      int checked;
      int hits;

      function void note(logic signed [VALUE_W-1:0] v, logic f);
         value_q.push_back(v);
         flag_q.push_back(f);
      endfunction

      function void check(logic signed [VALUE_W-1:0] v, logic f);
         logic signed [VALUE_W-1:0] ev;
         logic                      ef;
         if (value_q.size() == 0) begin
            $error("unexpected result: sample_value %0d in_range %0b", v, f);
            errors++;
            return;
         end
         ev = value_q.pop_front();
         ef = flag_q.pop_front();
         checked++;
         if (ef) hits++;
         if (v !== ev) begin
            $error("sample_value: expected %0d, actual %0d", ev, v);
            errors++;
         end
         if (f !== ef) begin
            $error("in_range: expected %0b, actual %0b", ef, f);
            errors++;
         end
      endfunction

      function int pending();
         return value_q.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_type = REQ_LOAD;
   logic [INDEX_W-1:0]        req_voxel_index = '0;
   logic signed [VOXEL_W-1:0] req_voxel_value = '0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_sample_value;
   logic                      rsp_in_range;

   sample_scoreboard sb = new();

   logic signed [VOXEL_W-1:0] voxel_mem [STORE_DEPTH];
   int                        burst_left = 0;
   int                        idle_cycles = 0;
   int                        n_load = 0;
   int                        n_sample = 0;
   int                        stall_left = 0;
   bit                        stall_mode = 0;

   trilinear_volume_sample i_dut (.*);

   always #5 clock = ~clock;

   function automatic bit split_axis(input logic signed [COORD_W-1:0] c,
                                     output int corner, output int frac);
      int t;
      t = int'(c) + CENTER;
      if (t < 0) return 0;
      corner = t >>> FRAC_BITS;
      if (corner > CORNER_MAX) return 0;
      frac = t & (ONE_W - 1);
      return 1;
   endfunction

   function automatic void predict_sample(input logic signed [COORD_W-1:0] cx, cy, cz,
                                          output logic signed [VALUE_W-1:0] v,
                                          output logic f);
      int     x, y, z, fx, fy, fz, w;
      longint acc, r;
      v = '0;
      f = 1'b0;
      if (!split_axis(cx, x, fx) || !split_axis(cy, y, fy) || !split_axis(cz, z, fz))
         return;
      acc = 0;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++) begin
               w = (i ? fx : ONE_W - fx) * (j ? fy : ONE_W - fy) * (k ? fz : ONE_W - fz);
               acc += longint'(w) *
                      longint'(voxel_mem[((x + i) * GRID_SIZE + y + j) * GRID_SIZE + z + k]);
            end
      r = (acc + (longint'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      v = r[VALUE_W-1:0];
      f = 1'b1;
   endfunction

   task automatic send(input logic kind, input int idx, input logic signed [VOXEL_W-1:0] val,
                       input logic signed [COORD_W-1:0] cx, cy, cz);
      logic signed [VALUE_W-1:0] v;
      logic                      f;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_voxel_index <= idx[INDEX_W-1:0];
      req_voxel_value <= val;
      req_coord_x     <= cx;
      req_coord_y     <= cy;
      req_coord_z     <= cz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind == REQ_LOAD) begin
         voxel_mem[idx] = val;
         n_load++;
      end else begin
         predict_sample(cx, cy, cz, v, f);
         sb.note(v, f);
         n_sample++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic signed [VOXEL_W-1:0] rand_voxel();
      case ($urandom_range(0, 5))
         0: return -16'sd32768;
         1: return 16'sd32767;
         default: return VOXEL_W'($urandom);
      endcase
   endfunction

   function automatic int vidx(int x, int y, int z);
      return (x * GRID_SIZE + y) * GRID_SIZE + z;
   endfunction

   function automatic logic signed [COORD_W-1:0] to_coord(int corner, int frac);
      return COORD_W'((corner - GRID_SIZE / 2) * ONE_W + frac);
   endfunction

   function automatic logic signed [COORD_W-1:0] out_coord();
      case ($urandom_range(0, 3))
         0: return to_coord(-1, $urandom_range(0, ONE_W - 1));
         1: return to_coord(CORNER_MAX + 1, $urandom_range(0, ONE_W - 1));
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic load_region(int lo, int hi);
      for (int x = lo; x <= hi; x++)
         for (int y = lo; y <= hi; y++)
            for (int z = lo; z <= hi; z++)
               send(REQ_LOAD, vidx(x, y, z), rand_voxel(), COORD_W'($urandom),
                    COORD_W'($urandom), COORD_W'($urandom));
   endtask

   task automatic random_sample();
      int base, span, x, y, z, axis;
      logic signed [COORD_W-1:0] c[3];
      case ($urandom_range(0, 2))
         0: begin base = 0; span = 3; end
         1: begin base = CORNER_MAX - 2; span = 3; end
         default: begin base = 14; span = 4; end
      endcase
      x = base + $urandom_range(0, span - 1);
      y = base + $urandom_range(0, span - 1);
      z = base + $urandom_range(0, span - 1);
      c[0] = to_coord(x, $urandom_range(0, ONE_W - 1));
      c[1] = to_coord(y, $urandom_range(0, ONE_W - 1));
      c[2] = to_coord(z, $urandom_range(0, ONE_W - 1));
      if ($urandom_range(0, 5) == 0) begin
         axis = $urandom_range(0, 2);
         c[axis] = out_coord();
      end
      send(REQ_SAMPLE, $urandom, VOXEL_W'($urandom), c[0], c[1], c[2]);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_region(0, 3);
      load_region(CORNER_MAX - 2, GRID_SIZE - 1);
      load_region(14, 18);
      send(REQ_LOAD, vidx(0, 0, 0), -16'sd32768, 0, 0, 0);
      send(REQ_LOAD, vidx(GRID_SIZE - 1, GRID_SIZE - 1, GRID_SIZE - 1), 16'sd32767,
           -1, -1, -1);

      // directed: volume edges, fraction extremes, out of range on each axis
      send(REQ_SAMPLE, 0, 0, to_coord(0, 0), to_coord(0, 0), to_coord(0, 0));
      send(REQ_SAMPLE, '1, -1, to_coord(CORNER_MAX, ONE_W - 1),
           to_coord(CORNER_MAX, ONE_W - 1), to_coord(CORNER_MAX, ONE_W - 1));
      send(REQ_SAMPLE, 0, 0, to_coord(16, 0), to_coord(16, 0), to_coord(16, 0));
      send(REQ_SAMPLE, 0, 0, to_coord(15, ONE_W / 2), to_coord(16, 1),
           to_coord(14, ONE_W - 1));
      send(REQ_SAMPLE, 0, 0, to_coord(0, ONE_W - 1), to_coord(1, 0), to_coord(2, 128));
      send(REQ_SAMPLE, 0, 0, to_coord(-1, ONE_W - 1), to_coord(0, 0), to_coord(0, 0));
      send(REQ_SAMPLE, 0, 0, to_coord(0, 0), to_coord(-1, ONE_W - 1), to_coord(0, 0));
      send(REQ_SAMPLE, 0, 0, to_coord(0, 0), to_coord(0, 0), to_coord(-1, ONE_W - 1));
      send(REQ_SAMPLE, 0, 0, to_coord(CORNER_MAX + 1, 0), to_coord(16, 0), to_coord(16, 0));
      send(REQ_SAMPLE, 0, 0, to_coord(16, 0), to_coord(CORNER_MAX + 1, 0), to_coord(16, 0));
      send(REQ_SAMPLE, 0, 0, to_coord(16, 0), to_coord(16, 0), to_coord(CORNER_MAX + 1, 0));
      send(REQ_SAMPLE, 0, 0, -16'sd32768, -16'sd32768, -16'sd32768);
      send(REQ_SAMPLE, 0, 0, 16'sd32767, 16'sd32767, 16'sd32767);
      // load then sample the same cell in consecutive requests
      send(REQ_LOAD, vidx(15, 15, 15), 16'sd32767, 16'sd32767, -16'sd32768, 0);
      send(REQ_SAMPLE, 0, 0, to_coord(15, 0), to_coord(15, 0), to_coord(15, 0));
      send(REQ_LOAD, vidx(15, 15, 15), -16'sd32768, 0, 0, 0);
      send(REQ_SAMPLE, 0, 0, to_coord(15, 0), to_coord(15, 0), to_coord(15, 0));
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) drain();
         case ($urandom_range(0, 9))
            0: send(REQ_LOAD, $urandom_range(0, STORE_DEPTH - 1), rand_voxel(),
                    COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            1, 2: send(REQ_LOAD, vidx($urandom_range(14, 18), $urandom_range(14, 18),
                       $urandom_range(14, 18)), rand_voxel(), COORD_W'($urandom),
                       COORD_W'($urandom), COORD_W'($urandom));
            default: random_sample();
         endcase
      end
      drain();

      $display("Run covered %0d loads and %0d samples, %0d of them inside the volume.",
               n_load, n_sample, sb.hits);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check(rsp_sample_value, rsp_in_range);
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 1);
            stall_left = $urandom_range(5, 60);
         end
         stall_left--;
         rsp_ready <= stall_mode ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== trilinear_volume_sample.f =====
rtl/core/tvs_pkg.sv
rtl/core/tvs_ram.sv
rtl/core/tvs_front.sv
rtl/core/tvs_datapath.sv
rtl/core/trilinear_volume_sample.sv
verif/tb_trilinear_volume_sample.sv
